/* src/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg: shared types and constants for the key matrix debouncer
// Beat layouts of the sample and result channels and the register map.
// ----------------------------------------------------------------------------
package kmd_pkg;

  // fixed field widths of the beats
  localparam int ROW_W  = 3;
  localparam int BITS_W = 16;
  localparam int TIME_W = 32;
  localparam int THR_W  = 16;
  localparam int CNT_W  = 8;
  // elapsed time clamped to just above any threshold
  localparam int EL_W   = THR_W + 1;

  // register map, word index
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd10;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // one sample beat: a raw row of the matrix
  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [BITS_W-1:0] raw_bits;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  // one result beat: debounced state of the row
  typedef struct packed {
    logic [ROW_W-1:0]  row_out;
    logic [BITS_W-1:0] stable_bits;
    logic [BITS_W-1:0] changed_bits;
    logic              scan_skipped;
  } result_t;

endpackage

/* src/kmd_row_mem.sv */
// ----------------------------------------------------------------------------
// kmd_row_mem: per-row state memory
// One entry per row holding stable levels and key counters. Registered read,
// one write port; a row never written reads as zero.
// ----------------------------------------------------------------------------
module kmd_row_mem #(
  parameter int ROWS = 8,
  parameter int AW   = 3,
  parameter int DW   = 144
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [ROWS];
  logic [ROWS-1:0] written;
  logic [DW-1:0] data_q;
  logic          written_q;

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // written flags stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = written_q ? data_q : '0;

endmodule

/* src/kmd_row_update.sv */
// ----------------------------------------------------------------------------
// kmd_row_update: counter update of one row
// For every column holding a key, compares raw against stable level, advances
// or clears the counter and flips the stable bit once the threshold is reached.
// ----------------------------------------------------------------------------
module kmd_row_update #(
  parameter int COLS = 16,
  parameter int KEYS = 128
) (
  input  logic [kmd_pkg::ROW_W-1:0]      row,
  input  logic [kmd_pkg::BITS_W-1:0]     raw_bits,
  input  logic [kmd_pkg::EL_W-1:0]       elapsed,
  input  logic [kmd_pkg::THR_W-1:0]      threshold,
  input  logic [COLS*(kmd_pkg::CNT_W+1)-1:0] entry,
  output logic [COLS*(kmd_pkg::CNT_W+1)-1:0] entry_next,
  output logic [kmd_pkg::BITS_W-1:0]     stable_bits,
  output logic [kmd_pkg::BITS_W-1:0]     changed_bits
);
  import kmd_pkg::*;

  localparam int SUM_W = EL_W + 1;

  logic [COLS-1:0]       stable_cur;
  logic [COLS-1:0]       stable_new;
  logic [COLS-1:0]       changed;
  logic [COLS*CNT_W-1:0] cnt_cur;
  logic [COLS*CNT_W-1:0] cnt_new;

  assign stable_cur = entry[COLS-1:0];
  assign cnt_cur    = entry[COLS*(CNT_W+1)-1:COLS];

  // one lane per column, all independent
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic             key_ok;
    stable_new = stable_cur;
    changed    = '0;
    cnt_new    = cnt_cur;
    for (int c = 0; c < COLS; c++) begin
      key_ok = (int'(row) * COLS + c) < KEYS;
      sum = SUM_W'(cnt_cur[c*CNT_W +: CNT_W]) + SUM_W'(elapsed);
      if (key_ok) begin
        if (raw_bits[c] == stable_cur[c]) begin
          cnt_new[c*CNT_W +: CNT_W] = '0;
        end else if (sum >= SUM_W'(threshold)) begin
          cnt_new[c*CNT_W +: CNT_W] = '0;
          stable_new[c] = ~stable_cur[c];
          changed[c]    = 1'b1;
        end else if (sum > SUM_W'(CNT_MAX)) begin
          cnt_new[c*CNT_W +: CNT_W] = CNT_MAX;
        end else begin
          cnt_new[c*CNT_W +: CNT_W] = sum[CNT_W-1:0];
        end
      end
    end
  end

  assign entry_next   = {cnt_new, stable_new};
  assign stable_bits  = BITS_W'(stable_new);
  assign changed_bits = BITS_W'(changed);

endmodule

/* src/key_matrix_debounce_top.sv */
// ----------------------------------------------------------------------------
// key_matrix_debounce_top: counter debouncer for a scanned key matrix
// Pipeline: a taken sample beat is registered in stage 1, then in the output register.
// Throughput: one row per cycle unless result_stall holds the pipeline; the row
// memory read-modify-write is pipelined, forwarding back-to-back same-row accesses.
// Reset: synchronous; counters and stable levels clear at once through per-row
// written flags, the scan time registers clear, the threshold returns to 10 ms.
// ----------------------------------------------------------------------------
module key_matrix_debounce_top #(
  parameter int ROWS = 8,
  parameter int COLS = 16,
  parameter int KEYS = 128
) (
  input  logic             clk,
  input  logic             rst,
  // sample channel
  input  logic             sample_valid,
  output logic             sample_stall,
  input  kmd_pkg::sample_t sample,
  // result channel
  output logic             result_valid,
  input  logic             result_stall,
  output kmd_pkg::result_t result,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import kmd_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DW = COLS * (CNT_W + 1);
  localparam logic [BITS_W-1:0] COL_MASK = BITS_W'((17'd1 << COLS) - 17'd1);

  // register port
  logic [THR_W-1:0] threshold;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(threshold) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  // pipeline control
  logic accept;
  logic s1_valid;
  logic s1_adv;
  logic out_adv;

  assign out_adv      = !result_valid || !result_stall;
  assign s1_adv       = s1_valid && out_adv;
  assign sample_stall = s1_valid && !out_adv;
  assign accept       = sample_valid && !sample_stall;

  // scan timing on the incoming beat
  logic [TIME_W-1:0] last_time_ms;
  logic [TIME_W-1:0] scan_elapsed;
  logic [TIME_W-1:0] el_now;
  logic [TIME_W-1:0] el_use;
  logic [EL_W-1:0]   el_clamp;
  logic              in_range;
  logic              row_zero;

  assign row_zero = sample.row_index == '0;
  assign in_range = int'(sample.row_index) < ROWS;
  assign el_now   = sample.now_ms - last_time_ms;
  assign el_use   = row_zero ? el_now : scan_elapsed;
  assign el_clamp = (|el_use[TIME_W-1:THR_W]) ? EL_W'(1) << THR_W
                                              : EL_W'(el_use[THR_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time_ms <= '0;
      scan_elapsed <= '0;
    end else if (accept && row_zero) begin
      scan_elapsed <= el_now;
      if (el_now != '0) begin
        last_time_ms <= sample.now_ms;
      end
    end
  end

  // row memory
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  assign rd_en   = accept && in_range;
  assign rd_addr = AW'(sample.row_index);

  kmd_row_mem #(
    .ROWS (ROWS),
    .AW   (AW),
    .DW   (DW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // stage 1: read in flight, forwarding of a write to the same row
  logic [ROW_W-1:0]  s1_row;
  logic [BITS_W-1:0] s1_raw;
  logic [EL_W-1:0]   s1_el;
  logic              s1_skip;
  logic              s1_in_range;
  logic              fwd_hit;
  logic [DW-1:0]     fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row      <= sample.row_index;
      s1_raw      <= sample.raw_bits;
      s1_el       <= el_clamp;
      s1_skip     <= !in_range || (el_use == '0);
      s1_in_range <= in_range;
      fwd_data    <= wr_data;
    end
  end

  // counter update of the row
  logic [DW-1:0]     entry;
  logic [BITS_W-1:0] upd_stable;
  logic [BITS_W-1:0] upd_changed;

  assign entry = fwd_hit ? fwd_data : rd_data;

  kmd_row_update #(
    .COLS (COLS),
    .KEYS (KEYS)
  ) u_update (
    .row          (s1_row),
    .raw_bits     (s1_raw),
    .elapsed      (s1_el),
    .threshold    (threshold),
    .entry        (entry),
    .entry_next   (wr_data),
    .stable_bits  (upd_stable),
    .changed_bits (upd_changed)
  );

  assign wr_en   = s1_adv && !s1_skip;
  assign wr_addr = AW'(s1_row);

  // output register
  result_t res_next;

  always_comb begin
    res_next.row_out = s1_row;
    if (!s1_in_range) begin
      res_next.stable_bits  = '0;
      res_next.changed_bits = '0;
      res_next.scan_skipped = 1'b1;
    end else if (s1_skip) begin
      res_next.stable_bits  = BITS_W'(entry[COLS-1:0]);
      res_next.changed_bits = '0;
      res_next.scan_skipped = 1'b1;
    end else begin
      res_next.stable_bits  = upd_stable;
      res_next.changed_bits = upd_changed;
      res_next.scan_skipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= res_next;
    end
  end

  // checks
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> int'(wr_addr) < ROWS)
    else $error("row memory written beyond the last row");

  a_skip_no_change: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.scan_skipped |-> result.changed_bits == '0)
    else $error("skipped row reports changed keys");

  a_cols_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.stable_bits | result.changed_bits) & ~COL_MASK) == '0)
    else $error("bits set beyond the last column");

  a_beat_moves: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("stage 1 beat lost on its way to the output register");

endmodule
